[rtl/core/assert_macros.svh]
// assertion macros shared by the predictor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GBP_ASSERT_IMP(lbl, ante, cons, msg)
`define GBP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/gbp_pkg.sv]
// types and constants of the gshare branch predictor
package gbp_pkg;

  localparam int unsigned SnapW   = 12;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned ThreadW = 2;

  typedef enum logic [2:0] {
    OP_PREDICT  = 3'd0,
    OP_RESOLVE  = 3'd1,
    OP_UNCOND   = 3'd2,
    OP_RESTORE  = 3'd3,
    OP_BTB_MISS = 3'd4
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [ThreadW-1:0] thread;
    logic [AddrW-1:0]   pc;
    logic               taken;
    logic               squashed;
    logic [SnapW-1:0]   saved_history;
  } in_t;

  typedef struct packed {
    logic             prediction;
    logic [SnapW-1:0] history_snapshot;
  } out_t;

endpackage

[rtl/core/gbp_history.sv]
// per-thread global history registers and table index generation
module gbp_history #(
  parameter int unsigned THREADS = 4,
  parameter int unsigned IDX_W   = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  gbp_pkg::in_t         in_i,
  output logic [IDX_W-1:0]     idx_o,
  output logic [gbp_pkg::SnapW-1:0] snap_o
);
  import gbp_pkg::*;

  localparam int unsigned TidW = (THREADS > 1) ? $clog2(THREADS) : 1;

  logic [IDX_W-1:0] hist_q [THREADS];
  logic [IDX_W-1:0] hist_cur;
  logic [IDX_W-1:0] hist_nxt;
  logic [4:0]       tid_red;
  logic [TidW-1:0]  tid;

  // thread number folded into range
  always_comb begin
    tid_red = 5'(in_i.thread);
    for (int k = 0; k < 4; k++) begin
      if (tid_red >= 5'(THREADS)) begin
        tid_red = tid_red - 5'(THREADS);
      end
    end
    tid = tid_red[TidW-1:0];
  end

  assign hist_cur = hist_q[tid];
  assign idx_o    = in_i.pc[IDX_W-1:0] ^ hist_cur;
  assign snap_o   = SnapW'(hist_cur);

  always_comb begin
    hist_nxt = hist_cur;
    unique case (in_i.opcode)
      OP_RESOLVE: begin
        if (in_i.squashed) begin
          hist_nxt = IDX_W'({in_i.saved_history, in_i.taken});
        end
      end
      OP_UNCOND:   hist_nxt = {hist_cur[IDX_W-2:0], 1'b1};
      OP_RESTORE:  hist_nxt = IDX_W'(in_i.saved_history);
      OP_BTB_MISS: hist_nxt = {hist_cur[IDX_W-1:1], 1'b0};
      default:     hist_nxt = hist_cur;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < THREADS; t++) begin
        hist_q[t] <= '0;
      end
    end else if (upd_i) begin
      hist_q[tid] <= hist_nxt;
    end
  end

endmodule

[rtl/core/gbp_counter_table.sv]
// saturating counter memory with clearing pass and write bypass
module gbp_counter_table #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned IDX_W         = 12,
  parameter int unsigned COUNTER_BITS  = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [IDX_W-1:0]        rd_idx_i,
  input  logic                    wr_en_i,
  input  logic [IDX_W-1:0]        wr_idx_i,
  input  logic [COUNTER_BITS-1:0] wr_data_i,
  output logic                    ready_o,
  output logic [COUNTER_BITS-1:0] ctr_o
);
  import gbp_pkg::*;

  logic [COUNTER_BITS-1:0] mem_q [TABLE_ENTRIES];
  logic [COUNTER_BITS-1:0] rdata_q;
  logic [IDX_W-1:0]        rd_idx_q;
  logic [IDX_W:0]          clr_cnt_q;
  logic                    byp_valid_q;
  logic [IDX_W-1:0]        byp_idx_q;
  logic [COUNTER_BITS-1:0] byp_data_q;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic [COUNTER_BITS-1:0] mem_wd;

  assign ready_o = clr_cnt_q[IDX_W];
  assign mem_we  = !ready_o || wr_en_i;
  assign mem_wa  = ready_o ? wr_idx_i : clr_cnt_q[IDX_W-1:0];
  assign mem_wd  = ready_o ? wr_data_i : '0;

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (!ready_o) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en_i) begin
      rdata_q  <= mem_q[rd_idx_i];
      rd_idx_q <= rd_idx_i;
    end
  end

  // last write, covers a read at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (wr_en_i) begin
      byp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      byp_idx_q  <= wr_idx_i;
      byp_data_q <= wr_data_i;
    end
  end

  assign ctr_o = (byp_valid_q && (byp_idx_q == rd_idx_q)) ? byp_data_q : rdata_q;

endmodule

[rtl/core/gshare_branch_predictor_core.sv]
// gshare branch predictor top level: history, counter table, result register
// an accepted input goes through the stage-1 register, then the result register
// throughput: one transaction per cycle unless stalled, one table read and write per cycle
// input stalls in the table clear or while a result is held by out_stall_i and s1 is full
// reset: histories clear at once; the counter table is then cleared one entry
// per cycle, entry by entry, with in_stall_o high throughout
`include "assert_macros.svh"
module gshare_branch_predictor_core #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned COUNTER_BITS  = 2,
  parameter int unsigned THREADS       = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  gbp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output gbp_pkg::out_t out_data_o
);
  import gbp_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  logic                    accept;
  logic [IdxW-1:0]         idx;
  logic [SnapW-1:0]        snap;
  logic                    tbl_ready;
  logic [COUNTER_BITS-1:0] ctr;
  logic [COUNTER_BITS-1:0] ctr_nxt;
  logic                    tbl_wr_en;
  logic                    s1_adv;
  logic                    s1_pred;

  logic                    s1_valid_q;
  opcode_e                 s1_op_q;
  logic                    s1_taken_q;
  logic                    s1_sq_q;
  logic [IdxW-1:0]         s1_idx_q;
  logic [SnapW-1:0]        s1_snap_q;
  logic                    out_valid_q;
  out_t                    out_data_q;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = !tbl_ready || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;

  gbp_history #(
    .THREADS(THREADS),
    .IDX_W  (IdxW)
  ) u_history (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .upd_i (accept),
    .in_i  (in_data_i),
    .idx_o (idx),
    .snap_o(snap)
  );

  gbp_counter_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IdxW),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_idx_i (idx),
    .wr_en_i  (tbl_wr_en),
    .wr_idx_i (s1_idx_q),
    .wr_data_i(ctr_nxt),
    .ready_o  (tbl_ready),
    .ctr_o    (ctr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= in_data_i.opcode;
      s1_taken_q <= in_data_i.taken;
      s1_sq_q    <= in_data_i.squashed;
      s1_idx_q   <= idx;
      s1_snap_q  <= snap;
    end
  end

  // counter training
  always_comb begin
    if (s1_taken_q) begin
      ctr_nxt = (ctr == {COUNTER_BITS{1'b1}}) ? ctr : ctr + 1'b1;
    end else begin
      ctr_nxt = (ctr == '0) ? ctr : ctr - 1'b1;
    end
  end

  assign tbl_wr_en = s1_valid_q && s1_adv && (s1_op_q == OP_RESOLVE) && !s1_sq_q;

  always_comb begin
    unique case (s1_op_q)
      OP_PREDICT: s1_pred = ctr[COUNTER_BITS-1];
      OP_UNCOND:  s1_pred = 1'b1;
      default:    s1_pred = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q.prediction       <= s1_pred;
      out_data_q.history_snapshot <= s1_snap_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `GBP_ASSERT_IMP(a_no_accept_in_clear, in_valid_i && !in_stall_o, tbl_ready, "transaction accepted during table clear")
  `GBP_ASSERT_IMP(a_no_train_in_clear, tbl_wr_en, tbl_ready, "counter write during table clear")
  `GBP_ASSERT_NXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_idx_q), "stage lost while stalled")
  `GBP_ASSERT_NXT(a_uncond_taken, s1_valid_q && s1_adv && s1_op_q == OP_UNCOND, out_valid_o && out_data_o.prediction, "unconditional branch not predicted taken")

endmodule
